// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define MSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Types and constants of the motion severity classifier.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_ARMED  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPIKE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TONIC  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLONIC = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUIET  = 3'd4;

    // Widths of the fixed result fields
    localparam int MAG_W   = 15;
    localparam int LEVEL_W = 3;
    localparam int RLVL_W  = 4;
    localparam int SPACE_W = 4;

    // Output word: 36 field bits filled up to 40
    localparam int OUT_TDATA_W = 40;

    // Threshold register reset values
    localparam logic [MAG_W-1:0] SPIKE_RST  = 15'd1200;
    localparam logic [MAG_W-1:0] TONIC_RST  = 15'd2000;
    localparam logic [MAG_W-1:0] CLONIC_RST = 15'd1500;
    localparam logic [MAG_W-1:0] QUIET_RST  = 15'd600;

    // Severity levels
    localparam logic [LEVEL_W-1:0] LVL_IDLE    = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_SPIKE   = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_TONIC   = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_CLONIC  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_EPISODE = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_POST    = 3'd5;

    // Reported level marker for "nothing reported yet"
    localparam logic [RLVL_W-1:0] LEVEL_NONE = 4'd9;

    // Input op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Magnitude saturation bound
    localparam logic [MAG_W-1:0] MAG_MAX = 15'd32767;

    // Counter limits of the level machine
    localparam int QUIET_CLEAR_RUN = 100;
    localparam int WEAK_SAMPLES    = 1000;
    localparam int WEAK_TONIC_HITS = 50;
    localparam int TONIC_ENTER     = 300;
    localparam int CLONIC_ENTER    = 500;
    localparam int EPISODE_ENTER   = 2000;
    localparam int POST_QUIET_RUN  = 200;

    // Periodic report spacing
    localparam logic [SPACE_W-1:0] REPORT_EVERY = 4'd10;

    // Configuration registers
    typedef struct packed {
        logic             armed;
        logic [MAG_W-1:0] spike_threshold;
        logic [MAG_W-1:0] tonic_threshold;
        logic [MAG_W-1:0] clonic_threshold;
        logic [MAG_W-1:0] quiet_threshold;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic               fast_rate;
        logic               report;
        logic               level_changed;
        logic [MAG_W-1:0]   peak;
        logic [MAG_W-1:0]   magnitude;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

// File: rtl/core/msc_engine.sv
// ----------------------------------------------------------------------------
// msc_engine
// Detection state and the level machine of the classifier.
// ----------------------------------------------------------------------------
module msc_engine #(
    parameter int SAMPLE_BITS = 14,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic                   op,
    input  logic [SAMPLE_BITS-1:0] sample_x,
    input  logic [SAMPLE_BITS-1:0] sample_y,
    input  msc_pkg::cfg_t          cfg,
    output msc_pkg::result_t       result
);
    import msc_pkg::*;

    localparam int SUM_W = 17;
    localparam logic [SAMPLE_BITS-1:0] CENTRE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // Detection state
    logic [LEVEL_W-1:0] level_reg,    level_next;
    logic [RLVL_W-1:0]  reported_reg, reported_next;
    logic [MAG_W-1:0]   peak_reg,     peak_next;
    cnt_t               samples_reg,  samples_next;
    cnt_t               tonic_reg,    tonic_next;
    cnt_t               clonic_reg,   clonic_next;
    cnt_t               quiet_reg,    quiet_next;
    cnt_t               episode_reg,  episode_next;
    logic [SPACE_W-1:0] spacing_reg,  spacing_next;
    logic               fast_reg,     fast_next;

    logic [SAMPLE_BITS-1:0] dev_x;
    logic [SAMPLE_BITS-1:0] dev_y;
    logic [SUM_W-1:0]       mag_sum;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       mag_out;
    logic                   auto_clear;
    logic                   report;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Magnitude: sum of axis deviations, saturated to 15 bits
    always_comb
    begin
        dev_x   = (sample_x > CENTRE) ? sample_x - CENTRE : CENTRE - sample_x;
        dev_y   = (sample_y > CENTRE) ? sample_y - CENTRE : CENTRE - sample_y;
        mag_sum = SUM_W'(dev_x) + SUM_W'(dev_y);
        mag     = (mag_sum > SUM_W'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];
    end

    // Level machine and counters for one word
    always_comb
    begin
        level_next    = level_reg;
        reported_next = reported_reg;
        peak_next     = peak_reg;
        samples_next  = samples_reg;
        tonic_next    = tonic_reg;
        clonic_next   = clonic_reg;
        quiet_next    = quiet_reg;
        episode_next  = episode_reg;
        spacing_next  = spacing_reg;
        fast_next     = fast_reg;
        mag_out       = '0;
        auto_clear    = 1'b0;
        report        = 1'b0;

        if (op == OP_CLEAR)
        begin
            level_next    = LVL_IDLE;
            reported_next = LEVEL_NONE;
            peak_next     = '0;
            samples_next  = '0;
            tonic_next    = '0;
            clonic_next   = '0;
            quiet_next    = '0;
            episode_next  = '0;
            spacing_next  = '0;
            fast_next     = 1'b0;
            report        = 1'b1;
        end
        else if (!cfg.armed)
        begin
            level_next = LVL_IDLE;
            quiet_next = '0;
        end
        else
        begin
            mag_out = mag;

            // Common bookkeeping
            if (mag > peak_reg)
                peak_next = mag;
            samples_next = sat_inc(samples_reg);
            if (level_reg inside {[LVL_TONIC:LVL_EPISODE]})
                episode_next = sat_inc(episode_reg);
            if (mag < cfg.quiet_threshold)
                quiet_next = sat_inc(quiet_reg);
            else
                quiet_next = '0;

            // Level moves
            if (level_reg inside {[LVL_SPIKE:LVL_CLONIC]} &&
                quiet_next > cnt_t'(QUIET_CLEAR_RUN))
            begin
                auto_clear = 1'b1;
            end
            else
            begin
                case (level_reg)
                    LVL_IDLE:
                    begin
                        if (mag > cfg.spike_threshold)
                        begin
                            level_next   = LVL_SPIKE;
                            samples_next = '0;
                            tonic_next   = '0;
                            clonic_next  = '0;
                            quiet_next   = '0;
                            episode_next = '0;
                            peak_next    = mag;
                            fast_next    = 1'b1;
                        end
                    end
                    LVL_SPIKE:
                    begin
                        if (mag > cfg.tonic_threshold)
                            tonic_next = sat_inc(tonic_reg);
                        if (tonic_next > cnt_t'(TONIC_ENTER))
                        begin
                            level_next   = LVL_TONIC;
                            samples_next = '0;
                            clonic_next  = '0;
                            quiet_next   = '0;
                            episode_next = '0;
                        end
                        // Too little tonic activity over a long window
                        if (samples_next > cnt_t'(WEAK_SAMPLES) &&
                            tonic_next < cnt_t'(WEAK_TONIC_HITS))
                            auto_clear = 1'b1;
                    end
                    LVL_TONIC:
                    begin
                        if (mag > cfg.clonic_threshold)
                            clonic_next = sat_inc(clonic_reg);
                        if (clonic_next > cnt_t'(CLONIC_ENTER))
                        begin
                            level_next   = LVL_CLONIC;
                            samples_next = '0;
                            quiet_next   = '0;
                        end
                    end
                    LVL_CLONIC:
                    begin
                        if (episode_next > cnt_t'(EPISODE_ENTER))
                        begin
                            level_next   = LVL_EPISODE;
                            samples_next = '0;
                            quiet_next   = '0;
                        end
                    end
                    LVL_EPISODE:
                    begin
                        if (quiet_next > cnt_t'(POST_QUIET_RUN))
                        begin
                            level_next   = LVL_POST;
                            samples_next = '0;
                        end
                    end
                    default:
                    begin
                        // post-episode quiet holds until a clear op or disarm
                    end
                endcase
            end

            // Drop all detection state on an automatic clear
            if (auto_clear)
            begin
                level_next    = LVL_IDLE;
                reported_next = LEVEL_NONE;
                peak_next     = '0;
                samples_next  = '0;
                tonic_next    = '0;
                clonic_next   = '0;
                quiet_next    = '0;
                episode_next  = '0;
                spacing_next  = '0;
                fast_next     = 1'b0;
                mag_out       = '0;
            end

            // Report on a new level or every tenth sample
            spacing_next = spacing_next + 1'b1;
            if ({1'b0, level_next} != reported_next || spacing_next >= REPORT_EVERY)
            begin
                report        = 1'b1;
                reported_next = {1'b0, level_next};
                spacing_next  = '0;
            end
        end
    end

    // Result of this word
    always_comb
    begin
        result.level         = level_next;
        result.magnitude     = mag_out;
        result.peak          = peak_next;
        result.level_changed = (level_next != level_reg);
        result.report        = report;
        result.fast_rate     = fast_next;
    end

    // Advance state once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= LVL_IDLE;
            reported_reg <= LEVEL_NONE;
            peak_reg     <= '0;
            samples_reg  <= '0;
            tonic_reg    <= '0;
            clonic_reg   <= '0;
            quiet_reg    <= '0;
            episode_reg  <= '0;
            spacing_reg  <= '0;
            fast_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            level_reg    <= level_next;
            reported_reg <= reported_next;
            peak_reg     <= peak_next;
            samples_reg  <= samples_next;
            tonic_reg    <= tonic_next;
            clonic_reg   <= clonic_next;
            quiet_reg    <= quiet_next;
            episode_reg  <= episode_next;
            spacing_reg  <= spacing_next;
            fast_reg     <= fast_next;
        end
    end

endmodule

// File: rtl/core/motion_severity_classifier_top.sv
// ----------------------------------------------------------------------------
// motion_severity_classifier_top
// Two-axis motion magnitude, peak tracking and severity level classifier.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// s_*       in         s_tvalid / s_tready    op, sample_x, sample_y
// m_*       out        m_tvalid / m_tready    level, magnitude, peak, flags
// APB       in/out     psel & penable         armed and four thresholds
//
// One word per cycle sustained while m_tready stays high; an accepted word
// passes the input register, then the result register, and shows on m_tdata
// while m_tvalid is high.
// The level machine updates its state in the cycle the word leaves the
// input register, so each word sees the state left by the word before it.
// rst_n clears the handshake and the detection state and loads the configuration reset values.
// A stalled m_tready holds the result register and, one word later, s_tready.
// ----------------------------------------------------------------------------
module motion_severity_classifier_top #(
    parameter int SAMPLE_BITS = 14,
    parameter int COUNT_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample_x, sample_y,
                                                                  // zero fill
    input  logic                            s_tuser,  // op

    // Result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msc_pkg::OUT_TDATA_W-1:0] m_tdata,  // level, magnitude, peak,
                                                      // level_changed, report,
                                                      // fast_rate, zero fill

    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [msc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [msc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import msc_pkg::*;

    localparam int IN_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int FIELD_W = 2 * SAMPLE_BITS;
    localparam int OUT_FIELD_W = $bits(result_t);

    cfg_t             cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic             cfg_write;

    logic                   in_valid_reg, in_valid_next;
    logic                   in_op_reg;
    logic [SAMPLE_BITS-1:0] in_x_reg;
    logic [SAMPLE_BITS-1:0] in_y_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg;
    result_t                step_result;
    logic                   s_accept;
    logic                   advance;
    logic                   step_en;
    logic [IN_TDATA_W-1:0]  in_word;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_ARMED:  cfg_next.armed            = pwdata[0];
                REG_SPIKE:  cfg_next.spike_threshold  = pwdata[MAG_W-1:0];
                REG_TONIC:  cfg_next.tonic_threshold  = pwdata[MAG_W-1:0];
                REG_CLONIC: cfg_next.clonic_threshold = pwdata[MAG_W-1:0];
                REG_QUIET:  cfg_next.quiet_threshold  = pwdata[MAG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_idx)
            REG_ARMED:  prdata = APB_DATA_W'(cfg_reg.armed);
            REG_SPIKE:  prdata = APB_DATA_W'(cfg_reg.spike_threshold);
            REG_TONIC:  prdata = APB_DATA_W'(cfg_reg.tonic_threshold);
            REG_CLONIC: prdata = APB_DATA_W'(cfg_reg.clonic_threshold);
            REG_QUIET:  prdata = APB_DATA_W'(cfg_reg.quiet_threshold);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.armed            <= 1'b1;
            cfg_reg.spike_threshold  <= SPIKE_RST;
            cfg_reg.tonic_threshold  <= TONIC_RST;
            cfg_reg.clonic_threshold <= CLONIC_RST;
            cfg_reg.quiet_threshold  <= QUIET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline handshake: advance when the result register is free or taken
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    assign in_word = s_tdata;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg <= s_tuser;
            in_x_reg  <= in_word[SAMPLE_BITS-1:0];
            in_y_reg  <= in_word[FIELD_W-1:SAMPLE_BITS];
        end
    end

    msc_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .op       (in_op_reg),
        .sample_x (in_x_reg),
        .sample_y (in_y_reg),
        .cfg      (cfg_reg),
        .result   (step_result)
    );

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (step_en)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_data_reg};

endmodule

// File: rtl/core/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [msc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import msc_pkg::*;

    result_t res;

    assign res = m_tdata[$bits(result_t)-1:0];

    // Result channel is empty after any edge seen in reset
    `MSC_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_tvalid, "result valid during reset")

    // A stalled result word holds
    `MSC_ASSERT(a_hold_on_stall, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")

    // Peak never falls below the magnitude it was built from
    `MSC_ASSERT(a_peak_ge_mag, clk, rst_n, m_tvalid |-> res.peak >= res.magnitude, "peak below magnitude")

    // Any active level runs at the fast rate
    `MSC_ASSERT(a_fast_when_active, clk, rst_n, m_tvalid && res.level != LVL_IDLE |-> res.fast_rate, "active level without fast rate")

endmodule

bind motion_severity_classifier_top msc_checker u_msc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
